// File: hw/rtl/ccpf_pkg.sv
// Shared types, constants and helpers for the calendar clock with period flags.
// Used by the top level, the remainder unit and the port checker; no dependencies.
package ccpf_pkg;

    // Field widths
    localparam int RUN_W       = 32;
    localparam int PERIOD_W    = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int FLAG_W      = 4;
    localparam int EVENT_W     = 5;

    // Request function codes
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_LOAD = 2'd1;
    localparam logic [1:0] FUNC_TAKE = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_COUNT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_0    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENDDAY_LEAD = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAVE_PERIOD = 3'd6;

    // Event bit positions
    localparam int EV_SECOND = 0;
    localparam int EV_MINUTE = 1;
    localparam int EV_ENDDAY = 2;
    localparam int EV_SAVE   = 3;
    localparam int EV_DATE   = 4;

    // Calendar constants
    localparam logic [7:0] SEC_PER_MIN   = 8'd60;
    localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
    localparam logic [6:0] MIN_ARM       = 7'd59;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;
    localparam logic [4:0] LAST_HOUR     = 5'd23;
    localparam logic [3:0] MONTH_WRAP    = 4'd13;
    localparam logic [4:0] FEB_LEAP      = 5'd29;
    localparam logic [4:0] FEB_PLAIN     = 5'd28;
    localparam logic [5:0] ELAPSED_MAX   = 6'd60;
    localparam logic [6:0] YEAR_MAX      = 7'd99;
    localparam logic [3:0] MONTH_MAX     = 4'd12;
    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [5:0] MINSEC_MAX    = 6'd59;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd60;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  elapsed_seconds;
        logic [6:0]  load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
        logic [31:0] load_unix_time;
        logic [1:0]  top_index;
        logic        clear_after_read;
    } ccpf_in_t;

    typedef struct packed {
        logic [6:0]  cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [6:0]  cur_second;
        logic [31:0] cur_unix_time;
        logic [3:0]  top_flags;
        logic        top_value;
        logic [4:0]  events;
        logic        time_valid;
    } ccpf_out_t;

    // Remainder unit request and response
    typedef struct packed {
        logic                start;
        logic [RUN_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } ccpf_mod_req_t;

    typedef struct packed {
        logic done;
        logic is_zero;
    } ccpf_mod_rsp_t;

    // Length of the month; code 14 reads as February, code 0 as 30 days, codes 13 and 15 as 31
    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2, 4'd14:                          len = leap ? FEB_LEAP : FEB_PLAIN;
            4'd0, 4'd4, 4'd6, 4'd9, 4'd11:        len = 5'd30;
            default:                              len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/calendar_clock_with_period_flags.sv
// A load, take, no-op or zero-second tick request goes from idle straight to the emit state,
// which registers its result once the output register is free. A tick first runs each period
// flag or save check that needs a remainder through the one shared 32-step remainder unit.
// The block is idle again once the result is registered. s_ready is low while a request is worked on;
// a finished result waits in the output register. Reset (aresetn, synchronous, active low)
// sets 00-01-01 00:00:00, clears flags, events and time_valid, and restores register defaults.
module calendar_clock_with_period_flags #(
    parameter int TOP_SLOTS = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ccpf_pkg::ccpf_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ccpf_pkg::ccpf_out_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [ccpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ccpf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [2:0] SAVE_SLOT = 3'd4;
    localparam logic [2:0] SCAN_END  = 3'd5;
    localparam logic [2:0] SLOTS_USED_MAX = 3'(TOP_SLOTS);
    localparam logic [ccpf_pkg::FLAG_W-1:0] SLOT_MASK = ccpf_pkg::FLAG_W'((1 << TOP_SLOTS) - 1);

    // Configuration registers
    logic [2:0]                      top_count_reg;
    logic [5:0]                      lead_reg;
    logic [ccpf_pkg::PERIOD_W-1:0]   save_period_reg;
    logic [ccpf_pkg::PERIOD_W-1:0]   period_pad [ccpf_pkg::FLAG_W];

    // Calendar and control state
    logic [1:0]  state_reg, state_next;
    logic [2:0]  cursor_reg, cursor_next;
    logic [6:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [6:0]  year_reg, year_next;
    logic [31:0] epoch_reg, epoch_next;
    logic [31:0] run_reg, run_next;
    logic [3:0]  pending_reg, pending_next;
    logic        armed_reg, armed_next;
    logic        leap_reg, leap_next;
    logic        valid_reg, valid_next;
    logic [4:0]  ev_reg, ev_next;
    logic        tv_reg, tv_next;
    logic        m_valid_reg, m_valid_next;
    ccpf_pkg::ccpf_out_t m_data_reg, m_data_next;

    // Tick arithmetic
    logic [5:0]  tick_el;
    logic [7:0]  sec_sum;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [3:0]  month_inc;
    logic [4:0]  month_len;
    logic [6:0]  t_sec;
    logic [5:0]  t_min;
    logic [4:0]  t_hour;
    logic [4:0]  t_day;
    logic [3:0]  t_month;
    logic [6:0]  t_year;
    logic        t_leap;
    logic        t_armed;
    logic [4:0]  t_ev;

    // Load saturation
    logic [6:0]  ld_year;
    logic [3:0]  ld_month;
    logic [4:0]  ld_day;
    logic [4:0]  ld_hour;
    logic [5:0]  ld_min;
    logic [5:0]  ld_sec;

    // Scan and take
    logic [2:0]                    used_slots;
    logic [1:0]                    cur_slot;
    logic                          slot_need;
    logic [ccpf_pkg::PERIOD_W-1:0] slot_divisor;
    logic                          take_hit;
    logic                          accept;

    ccpf_pkg::ccpf_mod_req_t mod_req;
    ccpf_pkg::ccpf_mod_rsp_t mod_rsp;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Write the scalar configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg   <= '0;
            lead_reg        <= '0;
            save_period_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ccpf_pkg::CFG_TOP_COUNT:   top_count_reg   <= cfg_data[2:0];
                ccpf_pkg::CFG_ENDDAY_LEAD: lead_reg        <= cfg_data[5:0];
                ccpf_pkg::CFG_SAVE_PERIOD: save_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold one period register per slot; slots past TOP_SLOTS read as zero
    for (genvar g = 0; g < ccpf_pkg::FLAG_W; g++) begin : g_period
        if (g < TOP_SLOTS) begin : g_used
            logic [ccpf_pkg::PERIOD_W-1:0] period_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    period_reg <= ccpf_pkg::PERIOD_RESET;
                end else if (cfg_we
                             && cfg_index == ccpf_pkg::CFG_INDEX_W'(ccpf_pkg::CFG_PERIOD_0 + g)) begin
                    period_reg <= cfg_data;
                end
            end
            assign period_pad[g] = period_reg;
        end else begin : g_unused
            assign period_pad[g] = '0;
        end
    end

    // Advance the calendar by one tick
    always_comb begin
        tick_el   = (s_data.elapsed_seconds > ccpf_pkg::ELAPSED_MAX) ? ccpf_pkg::ELAPSED_MAX
                                                                    : s_data.elapsed_seconds;
        sec_sum   = {1'b0, sec_reg} + {2'b00, tick_el};
        min_inc   = {1'b0, min_reg} + 7'd1;
        hour_inc  = {1'b0, hour_reg} + 6'd1;
        day_inc   = {1'b0, day_reg} + 6'd1;
        month_inc = month_reg + 4'd1;
        month_len = ccpf_pkg::days_in_month(month_reg, leap_reg);
        t_sec     = sec_sum[6:0];
        t_min     = min_reg;
        t_hour    = hour_reg;
        t_day     = day_reg;
        t_month   = month_reg;
        t_year    = year_reg;
        t_leap    = leap_reg;
        t_armed   = armed_reg;
        t_ev      = '0;
        t_ev[ccpf_pkg::EV_SECOND] = 1'b1;
        if (sec_sum >= ccpf_pkg::SEC_PER_MIN) begin
            t_sec = 7'(sec_sum - ccpf_pkg::SEC_PER_MIN);
            if (min_inc >= ccpf_pkg::MIN_PER_HOUR) begin
                t_min   = '0;
                t_armed = 1'b0;
                if (hour_inc >= ccpf_pkg::HOURS_PER_DAY) begin
                    t_hour = '0;
                    if (day_inc > {1'b0, month_len}) begin
                        t_day = 5'd1;
                        if (month_inc == ccpf_pkg::MONTH_WRAP) begin
                            t_month = 4'd1;
                            t_year  = (year_reg >= ccpf_pkg::YEAR_MAX) ? '0 : year_reg + 7'd1;
                            t_leap  = (t_year[1:0] == 2'b00);
                        end else begin
                            t_month = month_inc;
                        end
                    end else begin
                        t_day = day_inc[4:0];
                    end
                end else begin
                    t_hour = hour_inc[4:0];
                end
            end else begin
                t_min = min_inc[5:0];
                if (min_inc == ccpf_pkg::MIN_ARM) begin
                    t_armed = 1'b1;
                end
                t_ev[ccpf_pkg::EV_MINUTE] = 1'b1;
            end
        end
        // Fire the end-of-day warning once per arming
        if (t_armed && t_hour == ccpf_pkg::LAST_HOUR && t_sec >= {1'b0, lead_reg}) begin
            t_armed = 1'b0;
            t_ev[ccpf_pkg::EV_ENDDAY] = 1'b1;
        end
    end

    // Saturate load values
    always_comb begin
        ld_year  = (s_data.load_year > ccpf_pkg::YEAR_MAX) ? ccpf_pkg::YEAR_MAX
                                                           : s_data.load_year;
        ld_month = (s_data.load_month == '0) ? 4'd1
                 : (s_data.load_month > ccpf_pkg::MONTH_MAX) ? ccpf_pkg::MONTH_MAX
                 : s_data.load_month;
        ld_day   = (s_data.load_day == '0) ? 5'd1 : s_data.load_day;
        ld_hour  = (s_data.load_hour > ccpf_pkg::HOUR_MAX) ? ccpf_pkg::HOUR_MAX
                                                           : s_data.load_hour;
        ld_min   = (s_data.load_minute > ccpf_pkg::MINSEC_MAX) ? ccpf_pkg::MINSEC_MAX
                                                               : s_data.load_minute;
        ld_sec   = (s_data.load_second > ccpf_pkg::MINSEC_MAX) ? ccpf_pkg::MINSEC_MAX
                                                               : s_data.load_second;
    end

    // Select the check at the scan cursor
    always_comb begin
        used_slots = (top_count_reg > SLOTS_USED_MAX) ? SLOTS_USED_MAX : top_count_reg;
        cur_slot   = cursor_reg[1:0];
        take_hit   = ({1'b0, s_data.top_index} < used_slots);
        if (cursor_reg == SAVE_SLOT) begin
            slot_need    = valid_reg && (save_period_reg != '0);
            slot_divisor = save_period_reg;
        end else begin
            slot_need    = ({1'b0, cur_slot} < used_slots) && !pending_reg[cur_slot]
                           && (period_pad[cur_slot] != '0);
            slot_divisor = period_pad[cur_slot];
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        epoch_next   = epoch_reg;
        run_next     = run_reg;
        pending_next = pending_reg;
        armed_next   = armed_reg;
        leap_next    = leap_reg;
        valid_next   = valid_reg;
        ev_next      = ev_reg;
        tv_next      = tv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = run_reg;
        mod_req.divisor  = slot_divisor;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ev_next    = '0;
                    tv_next    = 1'b0;
                    state_next = ST_EMIT;
                    unique case (s_data.func)
                        ccpf_pkg::FUNC_TICK: begin
                            if (tick_el != '0) begin
                                sec_next    = t_sec;
                                min_next    = t_min;
                                hour_next   = t_hour;
                                day_next    = t_day;
                                month_next  = t_month;
                                year_next   = t_year;
                                leap_next   = t_leap;
                                armed_next  = t_armed;
                                ev_next     = t_ev;
                                run_next    = run_reg + {26'd0, tick_el};
                                epoch_next  = epoch_reg + {26'd0, tick_el};
                                cursor_next = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                        ccpf_pkg::FUNC_LOAD: begin
                            ev_next[ccpf_pkg::EV_DATE] = (ld_day != day_reg)
                                || (ld_month != month_reg) || (ld_year != year_reg);
                            year_next  = ld_year;
                            month_next = ld_month;
                            day_next   = ld_day;
                            hour_next  = ld_hour;
                            min_next   = ld_min;
                            sec_next   = {1'b0, ld_sec};
                            epoch_next = s_data.load_unix_time;
                            leap_next  = (ld_year[1:0] == 2'b00);
                            run_next   = {26'd0, ld_sec};
                            valid_next = 1'b1;
                        end
                        ccpf_pkg::FUNC_TAKE: begin
                            if (take_hit) begin
                                tv_next = pending_reg[s_data.top_index];
                                if (s_data.clear_after_read) begin
                                    pending_next[s_data.top_index] = 1'b0;
                                end
                            end
                        end
                        ccpf_pkg::FUNC_NOP: ;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (cursor_reg == SCAN_END) begin
                    state_next = ST_EMIT;
                end else if (slot_need) begin
                    mod_req.start = 1'b1;
                    state_next    = ST_WAIT;
                end else begin
                    cursor_next = cursor_reg + 3'd1;
                end
            end
            ST_WAIT: begin
                if (mod_rsp.done) begin
                    if (cursor_reg == SAVE_SLOT) begin
                        ev_next[ccpf_pkg::EV_SAVE] = mod_rsp.is_zero;
                    end else begin
                        pending_next[cur_slot] = mod_rsp.is_zero;
                    end
                    cursor_next = cursor_reg + 3'd1;
                    state_next  = ST_SCAN;
                end
            end
            ST_EMIT: begin
                // Hold here while the previous result still waits
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.cur_year      = year_reg;
                    m_data_next.cur_month     = month_reg;
                    m_data_next.cur_day       = day_reg;
                    m_data_next.cur_hour      = hour_reg;
                    m_data_next.cur_minute    = min_reg;
                    m_data_next.cur_second    = sec_reg;
                    m_data_next.cur_unix_time = epoch_reg;
                    m_data_next.top_flags     = pending_reg;
                    m_data_next.top_value     = tv_reg;
                    m_data_next.events        = ev_reg;
                    m_data_next.time_valid    = valid_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and calendar registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            sec_reg     <= '0;
            min_reg     <= '0;
            hour_reg    <= '0;
            day_reg     <= 5'd1;
            month_reg   <= 4'd1;
            year_reg    <= '0;
            epoch_reg   <= '0;
            run_reg     <= '0;
            pending_reg <= '0;
            armed_reg   <= 1'b0;
            leap_reg    <= 1'b1;
            valid_reg   <= 1'b0;
            ev_reg      <= '0;
            tv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            sec_reg     <= sec_next;
            min_reg     <= min_next;
            hour_reg    <= hour_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            epoch_reg   <= epoch_next;
            run_reg     <= run_next;
            pending_reg <= pending_next & SLOT_MASK;
            armed_reg   <= armed_next;
            leap_reg    <= leap_next;
            valid_reg   <= valid_next;
            ev_reg      <= ev_next;
            tv_reg      <= tv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    ccpf_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

endmodule

// File: hw/rtl/ccpf_mod_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one restoring step per cycle.
// Depends on ccpf_pkg for widths and the request/response structs.
module ccpf_mod_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ccpf_pkg::ccpf_mod_req_t req,
    output ccpf_pkg::ccpf_mod_rsp_t rsp
);

    localparam int CNT_W = $clog2(ccpf_pkg::RUN_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ccpf_pkg::RUN_W - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [ccpf_pkg::RUN_W-1:0]       dvd_reg;
    logic [ccpf_pkg::PERIOD_W-1:0]    dsr_reg;
    logic [ccpf_pkg::PERIOD_W-1:0]    rem_reg;
    logic [ccpf_pkg::PERIOD_W:0]      trial;
    logic [ccpf_pkg::PERIOD_W:0]      diff;
    logic [ccpf_pkg::PERIOD_W-1:0]    rem_next;

    // Shift in the next dividend bit, subtract the divisor where it fits
    always_comb begin
        trial    = {rem_reg, dvd_reg[ccpf_pkg::RUN_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = (trial >= {1'b0, dsr_reg}) ? diff[ccpf_pkg::PERIOD_W-1:0]
                                              : trial[ccpf_pkg::PERIOD_W-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ccpf_pkg::RUN_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.is_zero = (rem_reg == '0);

endmodule

// File: hw/rtl/ccpf_checker.sv
// Port-level checks for the calendar clock with period flags, bound to the top level.
// Depends on ccpf_pkg for the payload structs and event bit positions.
module ccpf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input ccpf_pkg::ccpf_in_t               s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input ccpf_pkg::ccpf_out_t              m_data
);

    // Waiting request holds its payload
    a_request_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting request dropped or changed");

    // One request at a time: not ready the cycle after a request
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block ready right after accepting a request");

    // Stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result dropped or changed");

    // Save requests only once a time has been loaded
    a_save_needs_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.events[ccpf_pkg::EV_SAVE] && !m_data.time_valid))
        else $error("save request without a loaded time");

    // Calendar fields stay in range
    a_calendar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cur_hour <= 5'd23 && m_data.cur_minute <= 6'd59
                    && m_data.cur_month >= 4'd1 && m_data.cur_month <= 4'd12)
        else $error("calendar field out of range");

endmodule

bind calendar_clock_with_period_flags ccpf_checker u_ccpf_checker (.*);

// File: test/tb_calendar_clock_with_period_flags.sv
// Self-checking testbench for the calendar clock with period flags.
// Depends on ccpf_pkg and calendar_clock_with_period_flags; predicts every result in-line.
`timescale 1ns / 100ps

module tb_calendar_clock_with_period_flags;

    localparam int          FLAG_SLOTS  = 4;
    localparam int          PHASES      = 7;
    localparam int          PHASE_ITEMS = 225;
    localparam int          LONG_HOLD   = 400;
    localparam int          TAIL_CYCLES = 200;
    localparam int unsigned RUN_LIMIT   = 2_000_000;

    localparam logic [ccpf_pkg::EVENT_W-1:0] EVS_SECOND =
        ccpf_pkg::EVENT_W'(1 << ccpf_pkg::EV_SECOND);
    localparam logic [ccpf_pkg::EVENT_W-1:0] EVS_MINUTE =
        ccpf_pkg::EVENT_W'(1 << ccpf_pkg::EV_MINUTE);
    localparam logic [ccpf_pkg::EVENT_W-1:0] EVS_DATE   =
        ccpf_pkg::EVENT_W'(1 << ccpf_pkg::EV_DATE);

    typedef struct packed {
        logic [2:0]                          flag_count;
        logic [3:0][ccpf_pkg::PERIOD_W-1:0]  period;
        logic [5:0]                          endday_lead;
        logic [ccpf_pkg::PERIOD_W-1:0]       save_period;
    } clock_settings_t;

    typedef struct packed {
        ccpf_pkg::ccpf_in_t  req;
        logic                pinned;
        ccpf_pkg::ccpf_out_t want;
    } stim_row_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    ccpf_pkg::ccpf_in_t               s_data    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    ccpf_pkg::ccpf_out_t              m_data;
    logic                             cfg_we    = 1'b0;
    logic [ccpf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ccpf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    ccpf_pkg::ccpf_out_t readings_due[$];
    int unsigned failures    = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_asked  = 0;
    int unsigned hold_served = 0;
    bit          no_idle     = 1'b0;

    // Predicted calendar, counters, flags and register copies
    int unsigned     now_second, now_minute, now_hour, now_day, now_month, now_year;
    logic [31:0]     now_epoch, run_count;
    logic [3:0]      flag_pending;
    bit              endday_armed, leap_feb, date_loaded;
    clock_settings_t regs;

    calendar_clock_with_period_flags #(
        .TOP_SLOTS (FLAG_SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always begin
        #10;
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    function automatic int unsigned month_length(input int unsigned month, input bit leap);
        int unsigned len;
        case (month)
            2:             len = leap ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // Advance the predicted clock by one request and return the reading it produces
    function automatic ccpf_pkg::ccpf_out_t clock_reading_after(input ccpf_pkg::ccpf_in_t req);
        ccpf_pkg::ccpf_out_t rd;
        int unsigned         el, used, idx;
        logic [4:0]          ev;
        logic                taken;
        int                  i;
        ev    = '0;
        taken = 1'b0;
        used  = (regs.flag_count > FLAG_SLOTS) ? FLAG_SLOTS : regs.flag_count;
        case (req.func)
            ccpf_pkg::FUNC_TICK: begin
                if (req.elapsed_seconds != 0) begin
                    el = (req.elapsed_seconds > 60) ? 60 : req.elapsed_seconds;
                    run_count += el;
                    now_epoch += el;
                    for (i = 0; i < used; i++)
                        if (!flag_pending[i] && regs.period[i] != 0)
                            flag_pending[i] = (run_count % regs.period[i]) == 0;
                    now_second += el;
                    // carry at most one minute, then ripple upward
                    if (now_second >= 60) begin
                        now_second -= 60;
                        now_minute++;
                        if (now_minute >= 60) begin
                            now_minute   = 0;
                            endday_armed = 1'b0;
                            now_hour++;
                            if (now_hour >= 24) begin
                                now_hour = 0;
                                now_day++;
                                if (now_day > month_length(now_month, leap_feb)) begin
                                    now_day = 1;
                                    now_month++;
                                    if (now_month == 13) begin
                                        now_month = 1;
                                        now_year  = (now_year >= 99) ? 0 : now_year + 1;
                                        leap_feb  = (now_year % 4) == 0;
                                    end
                                end
                            end
                        end else begin
                            if (now_minute == 59) endday_armed = 1'b1;
                            ev[ccpf_pkg::EV_MINUTE] = 1'b1;
                        end
                    end
                    ev[ccpf_pkg::EV_SECOND] = 1'b1;
                    if (endday_armed && now_hour == 23 && now_second >= regs.endday_lead) begin
                        endday_armed            = 1'b0;
                        ev[ccpf_pkg::EV_ENDDAY] = 1'b1;
                    end
                    if (date_loaded && regs.save_period != 0
                            && (run_count % regs.save_period) == 0)
                        ev[ccpf_pkg::EV_SAVE] = 1'b1;
                end
            end
            ccpf_pkg::FUNC_LOAD: begin
                // saturate the loaded date before comparing with the old one
                el   = (req.load_year > 99) ? 99 : req.load_year;
                used = (req.load_month < 1) ? 1 : ((req.load_month > 12) ? 12 : req.load_month);
                idx  = (req.load_day < 1) ? 1 : req.load_day;
                if (idx != now_day || used != now_month || el != now_year)
                    ev[ccpf_pkg::EV_DATE] = 1'b1;
                now_year    = el;
                now_month   = used;
                now_day     = idx;
                now_hour    = (req.load_hour > 23) ? 23 : req.load_hour;
                now_minute  = (req.load_minute > 59) ? 59 : req.load_minute;
                now_second  = (req.load_second > 59) ? 59 : req.load_second;
                now_epoch   = req.load_unix_time;
                leap_feb    = (now_year % 4) == 0;
                run_count   = now_second;
                date_loaded = 1'b1;
            end
            ccpf_pkg::FUNC_TAKE: begin
                idx = req.top_index;
                if (idx < used) begin
                    taken = flag_pending[idx];
                    if (req.clear_after_read) flag_pending[idx] = 1'b0;
                end
            end
            default: ;
        endcase
        rd.cur_year      = 7'(now_year);
        rd.cur_month     = 4'(now_month);
        rd.cur_day       = 5'(now_day);
        rd.cur_hour      = 5'(now_hour);
        rd.cur_minute    = 6'(now_minute);
        rd.cur_second    = 7'(now_second);
        rd.cur_unix_time = now_epoch;
        rd.top_flags     = flag_pending;
        rd.top_value     = taken;
        rd.events        = ev;
        rd.time_valid    = date_loaded;
        return rd;
    endfunction

    function automatic ccpf_pkg::ccpf_in_t random_request();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(ccpf_pkg::ccpf_in_t)-1:0];
    endfunction

    function automatic ccpf_pkg::ccpf_in_t tick_req(input int unsigned el);
        ccpf_pkg::ccpf_in_t r;
        r                 = random_request();
        r.func            = ccpf_pkg::FUNC_TICK;
        r.elapsed_seconds = 6'(el);
        return r;
    endfunction

    function automatic ccpf_pkg::ccpf_in_t load_req(input logic [6:0] y, input logic [3:0] mo,
                                                    input logic [4:0] d, input logic [4:0] h,
                                                    input logic [5:0] mi,
                                                    input logic [5:0] sec,
                                                    input logic [31:0] unix);
        ccpf_pkg::ccpf_in_t r;
        r                = random_request();
        r.func           = ccpf_pkg::FUNC_LOAD;
        r.load_year      = y;
        r.load_month     = mo;
        r.load_day       = d;
        r.load_hour      = h;
        r.load_minute    = mi;
        r.load_second    = sec;
        r.load_unix_time = unix;
        return r;
    endfunction

    function automatic ccpf_pkg::ccpf_in_t take_req(input logic [1:0] idx, input logic clr);
        ccpf_pkg::ccpf_in_t r;
        r                  = random_request();
        r.func             = ccpf_pkg::FUNC_TAKE;
        r.top_index        = idx;
        r.clear_after_read = clr;
        return r;
    endfunction

    function automatic ccpf_pkg::ccpf_in_t nop_req();
        ccpf_pkg::ccpf_in_t r;
        r      = random_request();
        r.func = ccpf_pkg::FUNC_NOP;
        return r;
    endfunction

    // Reading with no flags pending and nothing taken
    function automatic ccpf_pkg::ccpf_out_t reading(input logic [6:0] y, input logic [3:0] mo,
                                                    input logic [4:0] d, input logic [4:0] h,
                                                    input logic [5:0] mi,
                                                    input logic [6:0] sec,
                                                    input logic [31:0] unix,
                                                    input logic [4:0] ev,
                                                    input logic valid);
        ccpf_pkg::ccpf_out_t rd;
        rd               = '0;
        rd.cur_year      = y;
        rd.cur_month     = mo;
        rd.cur_day       = d;
        rd.cur_hour      = h;
        rd.cur_minute    = mi;
        rd.cur_second    = sec;
        rd.cur_unix_time = unix;
        rd.events        = ev;
        rd.time_valid    = valid;
        return rd;
    endfunction

    // Load placed close to a minute, day, month or year boundary
    function automatic ccpf_pkg::ccpf_in_t boundary_load();
        int unsigned y, mo, d, h, mi;
        case ($urandom_range(0, 3))
            0:       y = 99;
            1:       y = $urandom_range(0, 4);
            2:       y = $urandom_range(0, 99);
            default: y = $urandom_range(0, 127);
        endcase
        case ($urandom_range(0, 3))
            0, 1:    mo = 12;
            2:       mo = 2;
            default: mo = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 3))
            0, 1:    d = month_length(mo, (y % 4) == 0);
            2:       d = month_length(mo, (y % 4) == 0) - 1;
            default: d = $urandom_range(1, 31);
        endcase
        h  = ($urandom_range(0, 3) != 0) ? 23 : $urandom_range(0, 23);
        mi = ($urandom_range(0, 9) < 7) ? $urandom_range(57, 59) : $urandom_range(0, 59);
        return load_req(7'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'($urandom_range(0, 59)),
                        ($urandom_range(0, 3) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
                                                    : $urandom());
    endfunction

    function automatic logic [ccpf_pkg::PERIOD_W-1:0] pick_period();
        logic [ccpf_pkg::PERIOD_W-1:0] p;
        case ($urandom_range(0, 6))
            0:       p = '0;
            1, 2:    p = ccpf_pkg::PERIOD_W'($urandom_range(1, 20));
            3:       p = ccpf_pkg::PERIOD_W'($urandom_range(21, 900));
            4:       p = ($urandom_range(0, 1) != 0) ? 17'd3600 : 17'd86400;
            5:       p = ccpf_pkg::PERIOD_W'($urandom());
            default: p = '1;
        endcase
        return p;
    endfunction

    function automatic clock_settings_t phase_settings(input int phase);
        clock_settings_t s;
        int              i;
        for (i = 0; i < 4; i++) s.period[i] = pick_period();
        s.flag_count  = 3'($urandom_range(0, 7));
        s.endday_lead = 6'($urandom_range(0, 63));
        s.save_period = pick_period();
        case (phase)
            0: begin
                // short periods: flags set on almost every tick
                s.flag_count  = 3'd4;
                s.period      = {17'd60, 17'd3, 17'd2, 17'd1};
                s.endday_lead = 6'd0;
                s.save_period = 17'd60;
            end
            1: begin
                // count above the slot number, widest and zero periods
                s.flag_count  = 3'd7;
                s.period      = {17'h1FFFF, 17'd0, 17'd86400, 17'h1FFFF};
                s.endday_lead = 6'd59;
                s.save_period = 17'd86400;
            end
            2: begin
                s.flag_count  = 3'd2;
                s.period[0]   = ccpf_pkg::PERIOD_W'($urandom_range(1, 600));
                s.period[1]   = ccpf_pkg::PERIOD_W'($urandom_range(1, 600));
                s.period[2]   = 17'h1FFFF;
                s.endday_lead = 6'd63;
                s.save_period = 17'd1;
            end
            3: begin
                // no flags in use: earlier flags must stay visible
                s.flag_count  = 3'd0;
                s.endday_lead = 6'($urandom_range(0, 59));
                s.save_period = 17'd0;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    function automatic int unsigned idle_span();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Offer one request after a random gap and record its predicted reading
    task automatic offer(input ccpf_pkg::ccpf_in_t req, input logic pinned,
                         input ccpf_pkg::ccpf_out_t want);
        ccpf_pkg::ccpf_out_t rd;
        int unsigned         gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rd = clock_reading_after(req);
        readings_due.push_back(pinned ? want : rd);
    endtask

    // Drop valid and wait for every outstanding reading
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (readings_due.size() != 0) @(posedge aclk);
    endtask

    task automatic put_register(input logic [ccpf_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [ccpf_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input clock_settings_t s);
        int i;
        put_register(ccpf_pkg::CFG_TOP_COUNT, ccpf_pkg::CFG_DATA_W'(s.flag_count));
        for (i = 0; i < 4; i++)
            put_register(ccpf_pkg::CFG_PERIOD_0 + ccpf_pkg::CFG_INDEX_W'(i), s.period[i]);
        put_register(ccpf_pkg::CFG_ENDDAY_LEAD, ccpf_pkg::CFG_DATA_W'(s.endday_lead));
        put_register(ccpf_pkg::CFG_SAVE_PERIOD, s.save_period);
        cfg_we <= 1'b0;
        regs = s;
    endtask

    // Random mix: mostly a boundary load followed by a burst of ticks and takes
    task automatic run_phase(input int unsigned target, input bit with_hold,
                             input bit with_pause);
        int unsigned        accepted, burst;
        bit                 pressed;
        ccpf_pkg::ccpf_in_t req;
        accepted = 0;
        pressed  = 1'b0;
        while (accepted < target) begin
            if ($urandom_range(0, 9) < 7) begin
                offer(boundary_load(), 1'b0, '0);
                accepted++;
                burst = $urandom_range(3, 40);
                repeat (burst) begin
                    case ($urandom_range(0, 19)) inside
                        [0:14]:  req = tick_req(($urandom_range(0, 3) == 0)
                                                ? $urandom_range(0, 63)
                                                : $urandom_range(40, 60));
                        [15:18]: req = take_req(2'($urandom_range(0, 3)),
                                                1'($urandom_range(0, 1)));
                        default: req = nop_req();
                    endcase
                    offer(req, 1'b0, '0);
                    if (req.func != ccpf_pkg::FUNC_NOP) accepted++;
                end
            end else begin
                req = random_request();
                offer(req, 1'b0, '0);
                if (req.func != ccpf_pkg::FUNC_NOP) accepted++;
            end
            // halfway through: stall the result side, or pause the request side
            if (!pressed && accepted >= target / 2) begin
                pressed = 1'b1;
                if (with_hold) hold_asked++;
                if (with_pause) drain();
            end
        end
    endtask

    // Result side: random ready pattern plus the long hold-off on request
    initial begin : result_sink
        int unsigned span;
        logic        level;
        @(posedge aclk);
        forever begin
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                level       = 1'b0;
                span        = LONG_HOLD;
            end else if (no_idle || $urandom_range(0, 99) < 60) begin
                level = 1'b1;
                span  = no_idle ? 1 : $urandom_range(1, 8);
            end else begin
                level = 1'b0;
                span  = idle_span();
            end
            m_ready <= level;
            repeat (span) @(posedge aclk);
        end
    end

    // Compare each returned reading with the oldest prediction
    always @(posedge aclk) begin : result_check
        ccpf_pkg::ccpf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (readings_due.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, got %h", $time, m_data);
            end else begin
                want = readings_due.pop_front();
                check_field("cur_year", want.cur_year, m_data.cur_year);
                check_field("cur_month", want.cur_month, m_data.cur_month);
                check_field("cur_day", want.cur_day, m_data.cur_day);
                check_field("cur_hour", want.cur_hour, m_data.cur_hour);
                check_field("cur_minute", want.cur_minute, m_data.cur_minute);
                check_field("cur_second", want.cur_second, m_data.cur_second);
                check_field("cur_unix_time", want.cur_unix_time, m_data.cur_unix_time);
                check_field("top_flags", want.top_flags, m_data.top_flags);
                check_field("top_value", want.top_value, m_data.top_value);
                check_field("events", want.events, m_data.events);
                check_field("time_valid", want.time_valid, m_data.time_valid);
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        stim_row_t script[$];
        int        phase, row;

        // Reset state of the predictor and its register copies
        now_second   = 0;
        now_minute   = 0;
        now_hour     = 0;
        now_day      = 1;
        now_month    = 1;
        now_year     = 0;
        now_epoch    = '0;
        run_count    = '0;
        flag_pending = '0;
        endday_armed = 1'b0;
        leap_feb     = 1'b1;
        date_loaded  = 1'b0;
        regs         = '{flag_count: 3'd0, period: {4{ccpf_pkg::PERIOD_RESET}},
                         endday_lead: 6'd0, save_period: '0};

        // Directed rows: reset values, extremes, saturation, rollovers
        script.push_back('{nop_req(), 1'b1, reading(0, 1, 1, 0, 0, 0, 0, '0, 0)});
        script.push_back('{tick_req(0), 1'b1, reading(0, 1, 1, 0, 0, 0, 0, '0, 0)});
        script.push_back('{take_req(0, 1), 1'b1, reading(0, 1, 1, 0, 0, 0, 0, '0, 0)});
        script.push_back('{take_req(3, 0), 1'b1, reading(0, 1, 1, 0, 0, 0, 0, '0, 0)});
        script.push_back('{tick_req(60), 1'b1,
                           reading(0, 1, 1, 0, 1, 0, 60, EVS_SECOND | EVS_MINUTE, 0)});
        script.push_back('{tick_req(63), 1'b1,
                           reading(0, 1, 1, 0, 2, 0, 120, EVS_SECOND | EVS_MINUTE, 0)});
        script.push_back('{tick_req(1), 1'b1, reading(0, 1, 1, 0, 2, 1, 121, EVS_SECOND, 0)});
        script.push_back('{load_req(127, 15, 31, 31, 63, 63, 32'hFFFF_FFFF), 1'b1,
                           reading(99, 12, 31, 23, 59, 59, 32'hFFFF_FFFF, EVS_DATE, 1)});
        script.push_back('{load_req(0, 0, 0, 0, 0, 0, 0), 1'b1,
                           reading(0, 1, 1, 0, 0, 0, 0, EVS_DATE, 1)});
        script.push_back('{load_req(0, 1, 1, 5, 6, 7, 1234), 1'b1,
                           reading(0, 1, 1, 5, 6, 7, 1234, '0, 1)});
        script.push_back('{load_req(99, 12, 31, 23, 58, 30, 32'hFFFF_FFC0), 1'b0, '0});
        script.push_back('{tick_req(30), 1'b0, '0});
        script.push_back('{tick_req(60), 1'b0, '0});
        script.push_back('{tick_req(45), 1'b0, '0});
        script.push_back('{load_req(1, 2, 28, 23, 59, 50, 32'h1000_0000), 1'b0, '0});
        script.push_back('{tick_req(20), 1'b0, '0});
        script.push_back('{load_req(4, 2, 28, 23, 59, 50, 32'h2000_0000), 1'b0, '0});
        script.push_back('{tick_req(20), 1'b0, '0});
        script.push_back('{load_req(1, 2, 31, 23, 59, 59, 32'h3000_0000), 1'b0, '0});
        script.push_back('{tick_req(1), 1'b0, '0});
        script.push_back('{load_req(3, 12, 31, 23, 59, 59, 32'h4000_0000), 1'b0, '0});
        script.push_back('{tick_req(1), 1'b0, '0});
        script.push_back('{nop_req(), 1'b0, '0});
        script.push_back('{load_req(50, 13, 31, 24, 0, 0, 32'h5555_5555), 1'b0, '0});

        // Hold reset, then release it
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < script.size(); row++)
            offer(script[row].req, script[row].pinned, script[row].want);

        // One register setting per phase, written while the block is idle
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            apply_settings(phase_settings(phase));
            no_idle = (phase == 3);
            run_phase(PHASE_ITEMS, phase == 1, phase == 4);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
